// ===== design/sprite_quad_vertex_setup_core_macros.svh =====
// Assertion helpers used by the datapath.
`ifndef SPRITE_QUAD_VERTEX_SETUP_CORE_MACROS_SVH
`define SPRITE_QUAD_VERTEX_SETUP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SQVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SQVS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SQVS_ASSERT(lbl, prop, msg)
`define SQVS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== design/sqvs_pkg.sv =====
`default_nettype none
package sqvs_pkg;

  localparam int MaxSlots = 32;
  localparam int NumTex   = 32;
  localparam int InW      = 232;
  localparam int OutW     = 144;

  localparam logic [5:0]  SlotLimitReset = 6'd30;
  localparam logic [15:0] QuarterTurn    = 16'd16384;
  localparam logic [15:0] SineC1         = 16'd2320;
  localparam logic [15:0] SineC2         = 16'd21024;
  localparam logic [15:0] SineC3         = 16'd51472;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_Z2, MUL_T1, MUL_T2, MUL_S, MUL_WC, MUL_HS, MUL_WS, MUL_HC
  } mul_op_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SINE, ST_PROD, ST_EMIT
  } state_e;

  typedef struct packed {
    logic       accept;
    mul_op_e    mul_op;
    logic       phase;
    logic       emit;
    logic [1:0] corner;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_ang_zero;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/sqvs_ctrl.sv =====
`default_nettype none
module sqvs_ctrl import sqvs_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       phase_q, phase_d;
  logic [1:0] corner_q, corner_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= 2'd0;
      phase_q  <= 1'b0;
      corner_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
      corner_q <= corner_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    phase_d      = phase_q;
    corner_d     = corner_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.mul_op = MUL_NONE;
    cmd_o.phase  = phase_q;
    cmd_o.emit   = 1'b0;
    cmd_o.corner = corner_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          step_d   = 2'd0;
          phase_d  = 1'b0;
          corner_d = 2'd0;
          if (!status_i.in_kind) begin
            state_d = status_i.in_ang_zero ? ST_EMIT : ST_SINE;
          end
        end
      end
      ST_SINE: begin
        case (step_q)
          2'd0:    cmd_o.mul_op = MUL_Z2;
          2'd1:    cmd_o.mul_op = MUL_T1;
          2'd2:    cmd_o.mul_op = MUL_T2;
          default: cmd_o.mul_op = MUL_S;
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          phase_d = 1'b1;
          if (phase_q) begin
            state_d = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        case (step_q)
          2'd0:    cmd_o.mul_op = MUL_WC;
          2'd1:    cmd_o.mul_op = MUL_HS;
          2'd2:    cmd_o.mul_op = MUL_WS;
          default: cmd_o.mul_op = MUL_HC;
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          corner_d   = corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sqvs_datapath.sv =====
`default_nettype none
`include "sprite_quad_vertex_setup_core_macros.svh"
module sqvs_datapath import sqvs_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire  [InW-1:0]   in_data_i,
  input  wire              in_kind_i,
  input  wire              cfg_valid_i,
  input  wire  [5:0]       cfg_data_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  output logic [OutW-1:0]  out_data_o,
  output logic             out_last_o
);

  // Captured sprite.
  logic signed [23:0] x_q, y_q;
  logic [22:0] w_q, h_q;
  logic [15:0] u0_q, v0_q, du_q, dv_q, ang_q, dep_q;
  logic [4:0]  tex_q;
  logic [31:0] col_q;
  logic        added_q, full_q, zero_q;

  // Slot bookkeeping: a membership bit per texture slot mirrors the list.
  logic [5:0]        slot_limit_q;
  logic [5:0]        slot_count_q;
  logic [NumTex-1:0] slot_seen_q;
  logic [7:0]        lim;
  logic              found, room;

  // Arithmetic state.
  logic [14:0]        z2_q;
  logic [15:0]        t_q;
  logic signed [17:0] sn_q, cs_q;
  logic signed [41:0] wc_q, hs_q, ws_q, hc_q;

  logic               out_valid_q;
  logic [OutW-1:0]    out_data_q;
  logic               out_last_q;

  wire [15:0] in_ang = in_data_i[226:211];
  wire [4:0]  in_tex = in_data_i[162:158];

  assign lim   = ({2'b0, slot_limit_q} > 8'(MaxSlots)) ? 8'(MaxSlots) : {2'b0, slot_limit_q};
  assign found = slot_seen_q[in_tex];
  assign room  = {2'b0, slot_count_q} < lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= SlotLimitReset;
      slot_count_q <= 6'd0;
      slot_seen_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        slot_limit_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (in_kind_i) begin
          slot_count_q <= 6'd0;
          slot_seen_q  <= '0;
        end else if (!found && room) begin
          slot_count_q        <= slot_count_q + 6'd1;
          slot_seen_q[in_tex] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !in_kind_i) begin
      x_q     <= in_data_i[23:0];
      y_q     <= in_data_i[47:24];
      w_q     <= in_data_i[70:48];
      h_q     <= in_data_i[93:71];
      u0_q    <= in_data_i[125:110];
      v0_q    <= in_data_i[109:94];
      du_q    <= in_data_i[157:142];
      dv_q    <= in_data_i[141:126];
      tex_q   <= in_tex;
      col_q   <= in_data_i[194:163];
      dep_q   <= in_data_i[210:195];
      ang_q   <= in_ang;
      zero_q  <= (in_ang == 16'd0);
      added_q <= !found && room;
      full_q  <= !found && !room;
    end
  end

  // Quarter-wave argument for the sine or the cosine pass.
  logic [15:0] a_ph;
  logic [14:0] z;
  assign a_ph = cmd_i.phase ? ang_q + QuarterTurn : ang_q;
  assign z    = a_ph[14] ? 15'(QuarterTurn - {2'b0, a_ph[13:0]}) : {1'b0, a_ph[13:0]};

  logic signed [23:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [41:0] prod;
  logic [15:0]        prod_hi;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_Z2: begin mul_a = {9'b0, z};     mul_b = {3'b0, z};    end
      MUL_T1: begin mul_a = {8'b0, SineC1}; mul_b = {3'b0, z2_q}; end
      MUL_T2: begin mul_a = {8'b0, t_q};   mul_b = {3'b0, z2_q}; end
      MUL_S:  begin mul_a = {8'b0, t_q};   mul_b = {3'b0, z};    end
      MUL_WC: begin mul_a = {1'b0, w_q};   mul_b = cs_q;         end
      MUL_HS: begin mul_a = {1'b0, h_q};   mul_b = sn_q;         end
      MUL_WS: begin mul_a = {1'b0, w_q};   mul_b = sn_q;         end
      MUL_HC: begin mul_a = {1'b0, h_q};   mul_b = cs_q;         end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_hi = prod[29:14];

  logic signed [17:0] s_val;
  assign s_val = a_ph[15] ? -$signed({2'b0, prod_hi}) : $signed({2'b0, prod_hi});

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_op)
      MUL_Z2: z2_q <= prod[28:14];
      MUL_T1: t_q  <= SineC2 - prod_hi;
      MUL_T2: t_q  <= SineC3 - prod_hi;
      MUL_S: begin
        if (cmd_i.phase) cs_q <= s_val;
        else             sn_q <= s_val;
      end
      MUL_WC: wc_q <= prod;
      MUL_HS: hs_q <= prod;
      MUL_WS: ws_q <= prod;
      MUL_HC: hc_q <= prod;
      default: ;
    endcase
  end

  function automatic logic [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607)       return 24'h7FFFFF;
    else if (v < -28'sd8388608) return 24'h800000;
    else                        return v[23:0];
  endfunction

  logic               sx_pos, sy_pos;
  logic signed [43:0] bx, by, ax, ay;
  logic signed [25:0] zx, zy;
  logic [23:0]        px, py;
  logic [16:0]        su, sv;
  logic [15:0]        tu, tv;

  assign sx_pos = cmd_i.corner[1];
  assign sy_pos = ~(cmd_i.corner[1] ^ cmd_i.corner[0]);

  always_comb begin
    bx = (44'(x_q) <<< 16) + (44'($signed({1'b0, w_q})) <<< 15) + 44'sd32768;
    by = (44'(y_q) <<< 16) + (44'($signed({1'b0, h_q})) <<< 15) + 44'sd32768;
    ax = bx + (sx_pos ? 44'(wc_q) : -44'(wc_q)) - (sy_pos ? 44'(hs_q) : -44'(hs_q));
    ay = by + (sx_pos ? 44'(ws_q) : -44'(ws_q)) + (sy_pos ? 44'(hc_q) : -44'(hc_q));
    zx = 26'(x_q) + (sx_pos ? $signed({3'b0, w_q}) : 26'sd0);
    zy = 26'(y_q) + (sy_pos ? $signed({3'b0, h_q}) : 26'sd0);
    if (zero_q) begin
      px = sat24(28'(zx));
      py = sat24(28'(zy));
    end else begin
      px = sat24(ax[43:16]);
      py = sat24(ay[43:16]);
    end
    su = {1'b0, u0_q} + (sx_pos ? {1'b0, du_q} : 17'd0);
    sv = {1'b0, v0_q} + (sy_pos ? {1'b0, dv_q} : 17'd0);
    tu = su[16] ? 16'hFFFF : su[15:0];
    tv = sv[16] ? 16'hFFFF : sv[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {7'b0, full_q, added_q, dep_q, tex_q, col_q, tv, tu, py, px,
                     cmd_i.corner};
      out_last_q <= (cmd_i.corner == 2'd3);
    end
  end

  assign status_o.in_kind     = in_kind_i;
  assign status_o.in_ang_zero = (in_ang == 16'd0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  `SQVS_ASSERT_NR(a_count_matches_set, $countones(slot_seen_q) == 32'(slot_count_q), "slot count out of step with slot set")
  `SQVS_ASSERT(a_emit_only_when_free, cmd_i.emit |-> status_o.out_free, "vertex overwrote a pending beat")
  `SQVS_ASSERT(a_accept_not_during_emit, !(cmd_i.accept && (cmd_i.emit || cmd_i.mul_op != MUL_NONE)), "item taken while busy")

endmodule
`default_nettype wire

// ===== design/sprite_quad_vertex_setup_core.sv =====
// Sprite quad vertex setup.
// Slave stream: one beat per item. tuser is the kind (0 sprite, 1 begin frame);
// tdata carries the sprite description. A begin beat empties the texture slot
// list and produces no output.
// Master stream: four vertex beats per sprite, top-left, bottom-left,
// bottom-right, top-right; tlast marks the fourth.
// Configuration channel: cfg_data_i sets the slot limit; ready is always high.
// A rotated sprite first passes through the shared multiplier (two
// four-step sine polynomials and four corner products) before its first
// vertex, then gives one vertex per cycle while the receiver keeps up.
// A sprite with zero angle skips the multiplier.
// The next item is taken as soon as the fourth vertex sits in the output
// register, so its arithmetic overlaps the wait for the receiver.
// When the receiver stalls, vertices hold in the output register and the
// sequencer waits. Reset empties the slot list and sets the limit to 30;
// no output beat is pending after reset.
`default_nettype none
module sprite_quad_vertex_setup_core import sqvs_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  // dest_x, dest_y, dest_w, dest_h, uv_origin, uv_extent, texture, color,
  // depth, angle
  input  wire  [InW-1:0]   s_axis_tdata,
  // kind
  input  wire              s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  // corner, pos_x, pos_y, tex_u, tex_v, vertex_color, vertex_slot,
  // vertex_depth, slot_added, list_full
  output logic [OutW-1:0]  m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [5:0]       cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sqvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sqvs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sprite_quad_vertex_setup_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sprite_quad_vertex_setup_core_tb;
  import sqvs_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic              kind;
    logic [23:0]       dest_x;
    logic [23:0]       dest_y;
    logic [22:0]       dest_w;
    logic [22:0]       dest_h;
    logic [31:0]       uv_origin;
    logic [31:0]       uv_extent;
    logic [4:0]        texture;
    logic [31:0]       color;
    logic [15:0]       depth;
    logic [15:0]       angle;
  } sprite_t;

  typedef struct {
    logic [1:0]  corner;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] color;
    logic [4:0]  slot;
    logic [15:0] depth;
    logic        added;
    logic        full;
    logic        last;
  } vertex_t;

  class quad_scoreboard;
    vertex_t     vertex_q[$];
    logic [4:0]  slots[MaxSlots];
    int unsigned slot_count;
    logic [5:0]  slot_limit;
    int unsigned errors;
    int unsigned sprites, begins, vertices, full_seen;

    function new();
      slot_count = 0;
      slot_limit = SlotLimitReset;
      errors = 0;
      sprites = 0;
      begins = 0;
      vertices = 0;
      full_seen = 0;
    endfunction

    function longint quarter_sine(longint z);
      longint z2, t;
      z2 = (z * z) >> 14;
      t = (2320 * z2) >> 14;
      t = 21024 - t;
      t = (t * z2) >> 14;
      t = 51472 - t;
      return (t * z) >> 14;
    endfunction

    function longint turn_sine(logic [15:0] a);
      longint s;
      s = a[14] ? quarter_sine(16384 - a[13:0]) : quarter_sine(a[13:0]);
      return a[15] ? -s : s;
    endfunction

    function longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function int unsigned pending();
      return vertex_q.size();
    endfunction

    function void note_item(sprite_t s);
      bit found;
      logic added, full;
      longint x, y, w, h, sn, cs, px, py, ox, oy, tu, tv;
      int unsigned lim;
      vertex_t v;
      if (s.kind) begin
        slot_count = 0;
        begins++;
        return;
      end
      sprites++;
      found = 0;
      for (int i = 0; i < slot_count; i++)
        if (slots[i] == s.texture) found = 1;
      added = 0;
      full = 0;
      if (!found) begin
        lim = (slot_limit < MaxSlots) ? slot_limit : MaxSlots;
        if (slot_count < lim) begin
          slots[slot_count] = s.texture;
          slot_count++;
          added = 1;
        end else begin
          full = 1;
        end
      end
      x = longint'($signed(s.dest_x));
      y = longint'($signed(s.dest_y));
      w = longint'(s.dest_w);
      h = longint'(s.dest_h);
      sn = turn_sine(s.angle);
      cs = turn_sine(s.angle + 16'd16384);
      for (int k = 0; k < 4; k++) begin
        // Corner signs: x negative on the left pair, y positive on the top pair.
        ox = (k >= 2) ? w : -w;
        oy = (k == 0 || k == 3) ? h : -h;
        if (s.angle == 16'd0) begin
          px = x + ((k >= 2) ? w : 0);
          py = y + ((k == 0 || k == 3) ? h : 0);
        end else begin
          px = ((2 * x + w) * 32768 + ox * cs - oy * sn + 32768) >>> 16;
          py = ((2 * y + h) * 32768 + ox * sn + oy * cs + 32768) >>> 16;
        end
        px = sat24(px);
        py = sat24(py);
        tu = longint'(s.uv_origin[31:16]) + ((k >= 2) ? longint'(s.uv_extent[31:16]) : 0);
        tv = longint'(s.uv_origin[15:0])
             + ((k == 0 || k == 3) ? longint'(s.uv_extent[15:0]) : 0);
        v.corner = k[1:0];
        v.pos_x = px[23:0];
        v.pos_y = py[23:0];
        v.tex_u = (tu > 65535) ? 16'hFFFF : tu[15:0];
        v.tex_v = (tv > 65535) ? 16'hFFFF : tv[15:0];
        v.color = s.color;
        v.slot = s.texture;
        v.depth = s.depth;
        v.added = added;
        v.full = full;
        v.last = (k == 3);
        vertex_q.push_back(v);
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_vertex(logic [OutW-1:0] d, logic l);
      vertex_t e;
      vertices++;
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected vertex beat, corner", d[1:0], 0);
        return;
      end
      e = vertex_q.pop_front();
      if (e.full && e.corner == 0) full_seen++;
      if (d[1:0] != e.corner) report_mismatch("corner", d[1:0], e.corner);
      if (d[25:2] != e.pos_x) report_mismatch("pos_x", d[25:2], e.pos_x);
      if (d[49:26] != e.pos_y) report_mismatch("pos_y", d[49:26], e.pos_y);
      if (d[65:50] != e.tex_u) report_mismatch("tex_u", d[65:50], e.tex_u);
      if (d[81:66] != e.tex_v) report_mismatch("tex_v", d[81:66], e.tex_v);
      if (d[113:82] != e.color) report_mismatch("vertex_color", d[113:82], e.color);
      if (d[118:114] != e.slot) report_mismatch("vertex_slot", d[118:114], e.slot);
      if (d[134:119] != e.depth) report_mismatch("vertex_depth", d[134:119], e.depth);
      if (d[135] != e.added) report_mismatch("slot_added", d[135], e.added);
      if (d[136] != e.full) report_mismatch("list_full", d[136], e.full);
      if (l != e.last) report_mismatch("tlast", l, e.last);
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tlast;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [5:0]      cfg_data_i;

  quad_scoreboard sb;
  int unsigned    send_idle;
  int unsigned    recv_idle;
  int unsigned    hold_left;
  bit             hold_req;
  int unsigned    quiet_cycles;

  sprite_quad_vertex_setup_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_vertex(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("timeout: no beat accepted for %0d cycles", IdleLimit);
      $display("sprite_quad_vertex_setup_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(sprite_t s);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.kind;
    s_axis_tdata <= {5'd0, s.angle, s.depth, s.color, s.texture, s.uv_extent,
                     s.uv_origin, s.dest_h, s.dest_w, s.dest_y, s.dest_x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(s);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // A begin beat gives no output, so allow the longest sprite latency too.
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [5:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.slot_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sprite_t plain_sprite(logic [4:0] tex, logic [15:0] ang);
    sprite_t s;
    s.kind = 1'b0;
    s.dest_x = 24'd1000;
    s.dest_y = 24'hFFF000;
    s.dest_w = 23'd4096;
    s.dest_h = 23'd2048;
    s.uv_origin = 32'h1000_2000;
    s.uv_extent = 32'h0800_0400;
    s.texture = tex;
    s.color = 32'h11223344;
    s.depth = 16'h8000;
    s.angle = ang;
    return s;
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.kind = ($urandom_range(14) == 0);
    s.dest_x = 24'($urandom());
    s.dest_y = 24'($urandom());
    if ($urandom_range(3) == 0) begin
      s.dest_w = 23'($urandom());
      s.dest_h = 23'($urandom());
    end else begin
      s.dest_w = 23'($urandom_range(65535));
      s.dest_h = 23'($urandom_range(65535));
    end
    s.uv_origin = $urandom();
    s.uv_extent = $urandom();
    s.texture = $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    s.color = $urandom();
    s.depth = 16'($urandom());
    case ($urandom_range(7))
      0, 1: s.angle = 16'd0;
      2: s.angle = {2'($urandom_range(3)), 14'd0};
      default: s.angle = 16'($urandom());
    endcase
    return s;
  endfunction

  task automatic random_phase(int unsigned count);
    for (int i = 0; i < count; i++) send_item(random_sprite());
  endtask

  initial begin
    sprite_t s;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes of position and size, quadrant angles, uv saturation,
    // repeated and fresh slots, and a begin beat that empties the list.
    s = plain_sprite(5'd3, 16'd0);
    send_item(s);
    send_item(s);
    s.dest_x = 24'h7FFFFF; s.dest_y = 24'h7FFFFF;
    s.dest_w = 23'h7FFFFF; s.dest_h = 23'h7FFFFF;
    s.uv_origin = 32'hFFFF_FFFF; s.uv_extent = 32'hFFFF_FFFF;
    s.texture = 5'd31; s.color = 32'hFFFF_FFFF; s.depth = 16'h7FFF;
    send_item(s);
    s.angle = 16'd1;
    send_item(s);
    s.angle = 16'hFFFF;
    send_item(s);
    s.dest_x = 24'h800000; s.dest_y = 24'h800000;
    s.uv_origin = 32'd0; s.uv_extent = 32'd0;
    s.texture = 5'd0; s.color = 32'd0; s.depth = 16'd0;
    s.angle = 16'd0;
    send_item(s);
    s.angle = 16'h8000;
    send_item(s);
    for (int q = 1; q < 4; q++) send_item(plain_sprite(5'd3, {q[1:0], 14'd0}));
    send_item(plain_sprite(5'd9, 16'h2000));
    send_item(plain_sprite(5'd9, 16'hA5A5));
    s = plain_sprite(5'd0, 16'd0);
    s.dest_w = 23'd0; s.dest_h = 23'd0;
    send_item(s);
    s.kind = 1'b1;
    send_item(s);
    send_item(plain_sprite(5'd3, 16'h5A5A));
    drain();

    // Single-entry list: nearly every fresh slot hits the full flag.
    write_limit(6'd1);
    send_item(plain_sprite(5'd4, 16'd0));
    send_item(plain_sprite(5'd5, 16'd0));
    send_item(plain_sprite(5'd4, 16'h1234));
    send_idle = 16;
    recv_idle = 73;
    random_phase(100);
    drain();

    write_limit(6'd32);
    send_idle = 73;
    recv_idle = 16;
    random_phase(40);
    send_idle = 0;
    hold_req = 1'b1;
    random_phase(30);
    send_idle = 73;
    random_phase(40);
    drain();

    write_limit(6'd31);
    send_idle = 0;
    recv_idle = 0;
    random_phase(60);
    drain();

    write_limit(6'd4);
    random_phase(30);
    drain();

    $display("covered %0d sprites and %0d begin beats, checked %0d vertices",
             sb.sprites, sb.begins, sb.vertices);
    $display("slot limits 30, 1, 32, 31 and 4; %0d sprites found the list full",
             sb.full_seen);
    if (sb.errors == 0) begin
      $display("sprite_quad_vertex_setup_core_tb: clean");
    end else begin
      $display("sprite_quad_vertex_setup_core_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
